### rtl/yb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to BGR package
// Payload types, stage types and BT.601 fixed-point constants shared by the
// converter pipeline.
// ----------------------------------------------------------------------------
package yb_pkg;

	localparam int BYTE_W    = 8;
	localparam int OFFS_W    = BYTE_W + 1;
	localparam int COEF_W    = 16;
	localparam int PROD_W    = OFFS_W + COEF_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int FRAC_BITS = 13;

	localparam logic signed [COEF_W-1:0] COEF_Y   = 16'sd9535;
	localparam logic signed [COEF_W-1:0] COEF_B_U = 16'sd16531;
	localparam logic signed [COEF_W-1:0] COEF_G_V = 16'sd6660;
	localparam logic signed [COEF_W-1:0] COEF_G_U = 16'sd3203;
	localparam logic signed [COEF_W-1:0] COEF_R_V = 16'sd13074;

	localparam logic signed [OFFS_W-1:0] LUMA_OFFSET = 9'sd16;
	localparam logic signed [OFFS_W-1:0] CHROMA_MID  = 9'sd128;
	localparam logic [BYTE_W-1:0]        CHAN_MAX    = 8'd255;

	typedef struct packed {
		logic [BYTE_W-1:0] luma_first;
		logic [BYTE_W-1:0] chroma_u;
		logic [BYTE_W-1:0] luma_second;
		logic [BYTE_W-1:0] chroma_v;
		logic              last_in_frame;
	} yb_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] blue_first;
		logic [BYTE_W-1:0] green_first;
		logic [BYTE_W-1:0] red_first;
		logic [BYTE_W-1:0] blue_second;
		logic [BYTE_W-1:0] green_second;
		logic [BYTE_W-1:0] red_second;
		logic              frame_end;
	} yb_out_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] t_first;
		logic signed [PROD_W-1:0] t_second;
		logic signed [PROD_W-1:0] b_u;
		logic signed [PROD_W-1:0] g_v;
		logic signed [PROD_W-1:0] g_u;
		logic signed [PROD_W-1:0] r_v;
		logic                     last;
	} yb_prod_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] b_first;
		logic signed [SUM_W-1:0] g_first;
		logic signed [SUM_W-1:0] r_first;
		logic signed [SUM_W-1:0] b_second;
		logic signed [SUM_W-1:0] g_second;
		logic signed [SUM_W-1:0] r_second;
		logic                    last;
	} yb_sum_t;

endpackage
`default_nettype wire

### rtl/yb_streams.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to BGR stream interfaces
// Valid/ready channels for the macropixel input and the pixel pair output.
// ----------------------------------------------------------------------------
interface yb_yuyv_if;
	logic           valid;
	logic           ready;
	yb_pkg::yb_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface yb_bgr_if;
	logic            valid;
	logic            ready;
	yb_pkg::yb_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/yb_mul_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to BGR multiply stage
// Removes the luma and chroma offsets and forms the six coefficient products.
// ----------------------------------------------------------------------------
module yb_mul_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire yb_pkg::yb_in_t   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output yb_pkg::yb_prod_t      out_data
);

	localparam int PW = yb_pkg::PROD_W;

	logic                                 valid_s1;
	yb_pkg::yb_prod_t                     data_s1;
	yb_pkg::yb_prod_t                     prod;
	logic signed [yb_pkg::OFFS_W-1:0]     y_first;
	logic signed [yb_pkg::OFFS_W-1:0]     y_second;
	logic signed [yb_pkg::OFFS_W-1:0]     cb;
	logic signed [yb_pkg::OFFS_W-1:0]     cr;

	always_comb begin
		y_first  = $signed({1'b0, in_data.luma_first}) - yb_pkg::LUMA_OFFSET;
		y_second = $signed({1'b0, in_data.luma_second}) - yb_pkg::LUMA_OFFSET;
		cb       = $signed({1'b0, in_data.chroma_u}) - yb_pkg::CHROMA_MID;
		cr       = $signed({1'b0, in_data.chroma_v}) - yb_pkg::CHROMA_MID;

		prod.t_first  = PW'(y_first) * PW'(yb_pkg::COEF_Y);
		prod.t_second = PW'(y_second) * PW'(yb_pkg::COEF_Y);
		prod.b_u      = PW'(cb) * PW'(yb_pkg::COEF_B_U);
		prod.g_v      = PW'(cr) * PW'(yb_pkg::COEF_G_V);
		prod.g_u      = PW'(cb) * PW'(yb_pkg::COEF_G_U);
		prod.r_v      = PW'(cr) * PW'(yb_pkg::COEF_R_V);
		prod.last     = in_data.last_in_frame;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= prod;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

### rtl/yb_sum_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to BGR sum stage
// Combines the luma and chroma products into the six unscaled channels.
// ----------------------------------------------------------------------------
module yb_sum_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire yb_pkg::yb_prod_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output yb_pkg::yb_sum_t       out_data
);

	localparam int SW = yb_pkg::SUM_W;

	logic            valid_s2;
	yb_pkg::yb_sum_t data_s2;
	yb_pkg::yb_sum_t sum;

	always_comb begin
		sum.b_first  = SW'(in_data.t_first) + SW'(in_data.b_u);
		sum.g_first  = SW'(in_data.t_first) - SW'(in_data.g_v) - SW'(in_data.g_u);
		sum.r_first  = SW'(in_data.t_first) + SW'(in_data.r_v);
		sum.b_second = SW'(in_data.t_second) + SW'(in_data.b_u);
		sum.g_second = SW'(in_data.t_second) - SW'(in_data.g_v) - SW'(in_data.g_u);
		sum.r_second = SW'(in_data.t_second) + SW'(in_data.r_v);
		sum.last     = in_data.last;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= sum;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
`default_nettype wire

### rtl/yb_clamp_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to BGR clamp stage
// Scales each channel down by the fraction bits and clamps it to a byte; this
// stage is the output register.
// ----------------------------------------------------------------------------
module yb_clamp_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire yb_pkg::yb_sum_t  in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output yb_pkg::yb_out_t       out_data
);

	logic            valid_s3;
	yb_pkg::yb_out_t data_s3;
	yb_pkg::yb_out_t pix;

	function automatic logic [yb_pkg::BYTE_W-1:0] shift_clamp(
		input logic signed [yb_pkg::SUM_W-1:0] v
	);
		logic signed [yb_pkg::SUM_W-1:0] q;
		logic [yb_pkg::BYTE_W-1:0]       r;
		q = v >>> yb_pkg::FRAC_BITS;
		if (v < 0) begin
			r = '0;
		end else if (q[yb_pkg::SUM_W-1:yb_pkg::BYTE_W] != '0) begin
			r = yb_pkg::CHAN_MAX;
		end else begin
			r = q[yb_pkg::BYTE_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		pix.blue_first   = shift_clamp(in_data.b_first);
		pix.green_first  = shift_clamp(in_data.g_first);
		pix.red_first    = shift_clamp(in_data.r_first);
		pix.blue_second  = shift_clamp(in_data.b_second);
		pix.green_second = shift_clamp(in_data.g_second);
		pix.red_second   = shift_clamp(in_data.r_second);
		pix.frame_end    = in_data.last;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= pix;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule
`default_nettype wire

### rtl/yuyv_to_bgr_pixel_pair.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to BGR pixel pair converter
// Converts one YUYV macropixel per beat into two clamped BT.601 BGR pixels.
// Throughput: one macropixel per cycle; each of the three register stages
// (multiply, sum, shift and clamp) holds one beat and advances when the next
// stage is empty or moving.
// Reset: arst_n clears the stage valid bits only; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module yuyv_to_bgr_pixel_pair (
	input  wire logic clk,
	input  wire logic arst_n,
	yb_yuyv_if.sink   yuyv,
	yb_bgr_if.source  bgr
);

	logic             valid_1;
	logic             ready_1;
	yb_pkg::yb_prod_t data_1;
	logic             valid_2;
	logic             ready_2;
	yb_pkg::yb_sum_t  data_2;

	yb_mul_stage u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (yuyv.valid),
		.in_ready  (yuyv.ready),
		.in_data   (yuyv.data),
		.out_valid (valid_1),
		.out_ready (ready_1),
		.out_data  (data_1)
	);

	yb_sum_stage u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_1),
		.in_ready  (ready_1),
		.in_data   (data_1),
		.out_valid (valid_2),
		.out_ready (ready_2),
		.out_data  (data_2)
	);

	yb_clamp_stage u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_2),
		.in_ready  (ready_2),
		.in_data   (data_2),
		.out_valid (bgr.valid),
		.out_ready (bgr.ready),
		.out_data  (bgr.data)
	);

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_1 |-> yuyv.ready)
		else $error("first stage empty but input not ready");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_1 && !ready_1) |-> !yuyv.ready)
		else $error("input taken while first stage is stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(yuyv.valid && yuyv.ready) ##1 bgr.ready ##1 bgr.ready |=> bgr.valid)
		else $error("beat did not reach the output in three cycles");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(bgr.valid && !bgr.ready) |=> bgr.valid)
		else $error("stalled output beat dropped");

endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// YUYV to BGR pixel pair converter testbench
// Sends YUYV macropixels through the converter and predicts each BGR pixel
// pair with an independent BT.601 fixed-point calculation. Every output beat
// is compared field by field with the oldest predicted pair. Both sides stall
// at random, the receiver also holds off for a long stretch, and the last
// part of the run streams at full rate.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import yb_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int PIPE_LATENCY = 3;
	localparam int IDLE_LIMIT   = 1000;
	localparam int LONG_HOLD    = 64;

	localparam int K_LUMA      = 9535;
	localparam int K_BLUE_CB   = 16531;
	localparam int K_GREEN_CR  = 6660;
	localparam int K_GREEN_CB  = 3203;
	localparam int K_RED_CR    = 13074;
	localparam int FIXED_SHIFT = 13;
	localparam int BLACK_LEVEL = 16;
	localparam int CHROMA_ZERO = 128;
	localparam int BYTE_MAX    = 255;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	yb_yuyv_if yuyv_ch();
	yb_bgr_if  bgr_ch();

	yuyv_to_bgr_pixel_pair uut (
		.clk    (clk),
		.arst_n (arst_n),
		.yuyv   (yuyv_ch),
		.bgr    (bgr_ch)
	);

	yb_out_t pending_pairs[$];
	int      error_count = 0;
	int      idle_cycles = 0;
	bit      sender_gaps = 1'b0;
	bit      receiver_gaps = 1'b0;
	int      hold_off_cycles = 0;
	int      stall_left = 0;

	always #HALF_PERIOD clk = ~clk;

	function automatic logic [BYTE_W-1:0] clamp_channel(input int acc);
		int q;
		q = acc >>> FIXED_SHIFT;
		if (q < 0) begin
			return '0;
		end
		if (q > BYTE_MAX) begin
			return BYTE_MAX[BYTE_W-1:0];
		end
		return q[BYTE_W-1:0];
	endfunction

	function automatic yb_out_t convert_macropixel(input yb_in_t px);
		int cb, cr, t_first, t_second;
		yb_out_t pair;
		cb       = int'(px.chroma_u) - CHROMA_ZERO;
		cr       = int'(px.chroma_v) - CHROMA_ZERO;
		t_first  = K_LUMA * (int'(px.luma_first) - BLACK_LEVEL);
		t_second = K_LUMA * (int'(px.luma_second) - BLACK_LEVEL);
		pair.blue_first   = clamp_channel(t_first + K_BLUE_CB * cb);
		pair.green_first  = clamp_channel(t_first - K_GREEN_CR * cr - K_GREEN_CB * cb);
		pair.red_first    = clamp_channel(t_first + K_RED_CR * cr);
		pair.blue_second  = clamp_channel(t_second + K_BLUE_CB * cb);
		pair.green_second = clamp_channel(t_second - K_GREEN_CR * cr - K_GREEN_CB * cb);
		pair.red_second   = clamp_channel(t_second + K_RED_CR * cr);
		pair.frame_end    = px.last_in_frame;
		return pair;
	endfunction

	function automatic logic [BYTE_W-1:0] random_byte();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return BYTE_MAX[BYTE_W-1:0];
			default: return BYTE_W'($urandom_range(0, BYTE_MAX));
		endcase
	endfunction

	function automatic yb_in_t random_macropixel();
		yb_in_t px;
		px.luma_first    = random_byte();
		px.chroma_u      = random_byte();
		px.luma_second   = random_byte();
		px.chroma_v      = random_byte();
		px.last_in_frame = ($urandom_range(0, 15) == 0);
		return px;
	endfunction

	function automatic yb_in_t make_macropixel(input logic [7:0] y0, input logic [7:0] u,
			input logic [7:0] y1, input logic [7:0] v, input logic last);
		yb_in_t px;
		px.luma_first    = y0;
		px.chroma_u      = u;
		px.luma_second   = y1;
		px.chroma_v      = v;
		px.last_in_frame = last;
		return px;
	endfunction

	task automatic send_macropixel(input yb_in_t px);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			yuyv_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		yuyv_ch.valid <= 1'b1;
		yuyv_ch.data  <= px;
		do begin
			@(posedge clk);
		end while (!yuyv_ch.ready);
		pending_pairs.push_back(convert_macropixel(px));
	endtask

	task automatic end_burst();
		yuyv_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_pairs.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic report_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_pixel_pair(input yb_out_t got);
		yb_out_t want;
		if (pending_pairs.size() == 0) begin
			error_count++;
			$display("%0t: unexpected beat, expected none, actual %h", $time, got);
			return;
		end
		want = pending_pairs.pop_front();
		report_field("blue_first", want.blue_first, got.blue_first);
		report_field("green_first", want.green_first, got.green_first);
		report_field("red_first", want.red_first, got.red_first);
		report_field("blue_second", want.blue_second, got.blue_second);
		report_field("green_second", want.green_second, got.green_second);
		report_field("red_second", want.red_second, got.red_second);
		report_field("frame_end", want.frame_end, got.frame_end);
	endtask

	initial begin
		bgr_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (bgr_ch.valid && bgr_ch.ready) begin
				check_pixel_pair(bgr_ch.data);
			end
			if (!arst_n) begin
				bgr_ch.ready <= 1'b0;
			end else if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				bgr_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				bgr_ch.ready <= 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 5) - 1;
				bgr_ch.ready <= 1'b0;
			end else begin
				bgr_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (yuyv_ch.valid && yuyv_ch.ready) || (bgr_ch.valid && bgr_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_reference_points();
		send_macropixel(make_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		send_macropixel(make_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
		send_macropixel(make_macropixel(8'd16, 8'd128, 8'd235, 8'd128, 1'b0));
		send_macropixel(make_macropixel(8'd17, 8'd128, 8'd15, 8'd128, 1'b0));
		send_macropixel(make_macropixel(8'd126, 8'd128, 8'd127, 8'd128, 1'b1));
		send_macropixel(make_macropixel(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0));
		send_macropixel(make_macropixel(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1));
		end_burst();
	endtask

	task automatic test_clamping();
		send_macropixel(make_macropixel(8'd16, 8'd0, 8'd40, 8'd0, 1'b0));
		send_macropixel(make_macropixel(8'd255, 8'd255, 8'd200, 8'd128, 1'b0));
		send_macropixel(make_macropixel(8'd16, 8'd255, 8'd30, 8'd255, 1'b0));
		send_macropixel(make_macropixel(8'd235, 8'd0, 8'd255, 8'd0, 1'b0));
		send_macropixel(make_macropixel(8'd240, 8'd128, 8'd250, 8'd255, 1'b1));
		send_macropixel(make_macropixel(8'd20, 8'd128, 8'd10, 8'd0, 1'b0));
		send_macropixel(make_macropixel(8'd1, 8'd129, 8'd254, 8'd127, 1'b0));
		send_macropixel(make_macropixel(8'd128, 8'd1, 8'd128, 8'd254, 1'b1));
		end_burst();
	endtask

	task automatic test_random_stream(input int count);
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		repeat (count) begin
			send_macropixel(random_macropixel());
		end
		end_burst();
	endtask

	task automatic test_output_hold_off();
		sender_gaps     = 1'b0;
		hold_off_cycles = LONG_HOLD;
		repeat (80) begin
			send_macropixel(random_macropixel());
		end
		end_burst();
	endtask

	task automatic test_sender_pause();
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		repeat (40) begin
			send_macropixel(random_macropixel());
		end
		end_burst();
		wait_drained();
		repeat (40) begin
			send_macropixel(random_macropixel());
		end
		end_burst();
	endtask

	task automatic test_full_rate(input int count);
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		repeat (count) begin
			send_macropixel(random_macropixel());
		end
		end_burst();
	endtask

	initial begin
		yuyv_ch.valid = 1'b0;
		yuyv_ch.data  = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reference_points();
		test_clamping();
		test_random_stream(550);
		test_output_hold_off();
		test_sender_pause();
		test_full_rate(280);

		while (pending_pairs.size() != 0) begin
			@(posedge clk);
		end
		repeat (PIPE_LATENCY + 5) @(posedge clk);
		if (error_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
